// ----- hdl/lpg_pkg.sv -----
// shared types and constants for the line pixel generator
// no dependencies; used by lpg_setup and line_pixel_generator_top
package lpg_pkg;

  localparam int COORD_BITS  = 11;
  localparam int COLOUR_BITS = 16;
  localparam int SIZE_BITS   = 10;
  localparam int DELTA_BITS  = COORD_BITS + 1;
  localparam int ERR_BITS    = COORD_BITS + 2;

  localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOUR_BITS;
  localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOUR_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(320);
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(240);

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic                         steep;
    coord_t                       major_pos;
    coord_t                       minor_pos;
    coord_t                       major_end;
    logic [DELTA_BITS-1:0]        major_delta;
    logic [DELTA_BITS-1:0]        minor_delta;
    logic signed [ERR_BITS-1:0]   error_term;
    logic                         minor_down;
  } line_setup_t;

endpackage

// ----- hdl/lpg_setup.sv -----
// line setup: axis swap, endpoint ordering, deltas and initial error term
// depends on lpg_pkg
module lpg_setup import lpg_pkg::*; (
  input  coord_t      start_x,
  input  coord_t      start_y,
  input  coord_t      end_x,
  input  coord_t      end_y,
  output line_setup_t setup
);

  logic signed [DELTA_BITS-1:0] dx;
  logic signed [DELTA_BITS-1:0] dy;
  logic [DELTA_BITS-1:0]        adx;
  logic [DELTA_BITS-1:0]        ady;
  logic                         steep;
  coord_t                       a0, b0, a1, b1;
  logic                         swap;
  coord_t                       minor_end;
  logic [DELTA_BITS-1:0]        major_delta;

  always_comb begin
    dx = $signed({end_x[COORD_BITS-1], end_x}) - $signed({start_x[COORD_BITS-1], start_x});
    dy = $signed({end_y[COORD_BITS-1], end_y}) - $signed({start_y[COORD_BITS-1], start_y});
    adx = dx[DELTA_BITS-1] ? DELTA_BITS'(-dx) : DELTA_BITS'(dx);
    ady = dy[DELTA_BITS-1] ? DELTA_BITS'(-dy) : DELTA_BITS'(dy);
    steep = ady > adx;

    a0 = steep ? start_y : start_x;
    b0 = steep ? start_x : start_y;
    a1 = steep ? end_y   : end_x;
    b1 = steep ? end_x   : end_y;
    swap = a0 > a1;

    major_delta = steep ? ady : adx;

    setup.steep       = steep;
    setup.major_pos   = swap ? a1 : a0;
    setup.minor_pos   = swap ? b1 : b0;
    setup.major_end   = swap ? a0 : a1;
    minor_end         = swap ? b0 : b1;
    setup.major_delta = major_delta;
    setup.minor_delta = steep ? adx : ady;
    setup.error_term  = ERR_BITS'(0) - $signed({2'b00, major_delta[DELTA_BITS-1:1]});
    setup.minor_down  = !(setup.minor_pos < minor_end);
  end

endmodule

// ----- hdl/line_pixel_generator_top.sv -----
// top level of the line pixel generator: stream ports, line state, step logic
// depends on lpg_pkg and lpg_setup

// One item is taken per clock while the input side is ready. A load item sets up
// the line state in the cycle it is accepted and gives no output; a step item while
// a line is active puts one pixel into the output register at the next edge. The
// input side is ready whenever the output register is empty or being taken in the
// same cycle, so with a ready sink the block draws one pixel per clock, both
// endpoints included. A step with no active line is taken and dropped. Screen size
// writes should be made while no pixel is pending.
module line_pixel_generator_top import lpg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // start_x, start_y, end_x, end_y, pen_colour, zero fill
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
  // op
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // pixel_x, pixel_y, pixel_colour, zero fill
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
  // on_screen
  output logic                     m_axis_tuser,
  output logic                     m_axis_tlast,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [SIZE_BITS-1:0]     cfg_data
);

  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;

  logic                       line_active;
  logic                       steep_flag;
  coord_t                     major_pos;
  coord_t                     minor_pos;
  coord_t                     major_end;
  logic [DELTA_BITS-1:0]      major_delta;
  logic [DELTA_BITS-1:0]      minor_delta;
  logic signed [ERR_BITS-1:0] error_term;
  logic                       minor_down;
  logic [COLOUR_BITS-1:0]     held_colour;

  coord_t                 pixel_x;
  coord_t                 pixel_y;
  logic [COLOUR_BITS-1:0] pixel_colour;
  logic                   on_screen;
  logic                   last_pixel;

  line_setup_t setup;
  coord_t      in_start_x, in_start_y, in_end_x, in_end_y;
  logic [COLOUR_BITS-1:0] in_colour;

  logic                       in_fire;
  logic                       load_fire;
  logic                       step_fire;
  coord_t                     px, py;
  logic                       px_ok, py_ok, on_now, last_now;
  logic signed [ERR_BITS-1:0] err_acc;
  logic signed [ERR_BITS-1:0] error_term_next;
  coord_t                     minor_pos_next;

  assign in_start_x = s_axis_tdata[COORD_BITS-1:0];
  assign in_start_y = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
  assign in_end_x   = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
  assign in_end_y   = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];
  assign in_colour  = s_axis_tdata[IN_FIELD_BITS-1:4*COORD_BITS];

  lpg_setup u_setup (
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .setup   (setup)
  );

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign load_fire = in_fire && (s_axis_tuser == OP_LOAD);
  assign step_fire = in_fire && (s_axis_tuser == OP_STEP) && line_active;

  always_comb begin
    px = steep_flag ? minor_pos : major_pos;
    py = steep_flag ? major_pos : minor_pos;
    px_ok = !px[COORD_BITS-1] &&
            ($unsigned(px) < {{(COORD_BITS-SIZE_BITS){1'b0}}, screen_width});
    py_ok = !py[COORD_BITS-1] &&
            ($unsigned(py) < {{(COORD_BITS-SIZE_BITS){1'b0}}, screen_height});
    on_now   = px_ok && py_ok;
    last_now = major_pos >= major_end;

    err_acc = error_term + $signed({1'b0, minor_delta});
    if (err_acc > 0) begin
      error_term_next = err_acc - $signed({1'b0, major_delta});
      minor_pos_next  = minor_down ? minor_pos - coord_t'(1) : minor_pos + coord_t'(1);
    end else begin
      error_term_next = err_acc;
      minor_pos_next  = minor_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  screen_width  <= cfg_data;
        REG_HEIGHT: screen_height <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (load_fire) begin
      line_active <= 1'b1;
    end else if (step_fire && last_now) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fire) begin
      steep_flag  <= setup.steep;
      major_pos   <= setup.major_pos;
      minor_pos   <= setup.minor_pos;
      major_end   <= setup.major_end;
      major_delta <= setup.major_delta;
      minor_delta <= setup.minor_delta;
      error_term  <= setup.error_term;
      minor_down  <= setup.minor_down;
      held_colour <= in_colour;
    end else if (step_fire && !last_now) begin
      major_pos  <= major_pos + coord_t'(1);
      minor_pos  <= minor_pos_next;
      error_term <= error_term_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (step_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      pixel_x      <= px;
      pixel_y      <= py;
      pixel_colour <= held_colour;
      on_screen    <= on_now;
      last_pixel   <= last_now;
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}},
                         pixel_colour, pixel_y, pixel_x};
  assign m_axis_tuser = on_screen;
  assign m_axis_tlast = last_pixel;

  a_step_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    step_fire |=> m_axis_tvalid)
    else $error("step on an active line gave no pixel");

  a_load_arms_line: assert property (@(posedge clk) disable iff (rst)
    load_fire |=> line_active)
    else $error("load did not start a line");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    step_fire && last_now && !load_fire |=> !line_active)
    else $error("line still active after its last pixel");

  a_major_in_range: assert property (@(posedge clk) disable iff (rst)
    line_active |-> major_pos <= major_end)
    else $error("major position ran past the line end");

endmodule
